// File: src/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg: shared types and constants for the 3x3 matrix inverse
// Element, cofactor and determinant types, the cofactor index table and
// the stage records of the quotient pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

   localparam int IN_FRAC_BITS  = 8;
   localparam int OUT_FRAC_BITS = 16;
   localparam int SCALE         = IN_FRAC_BITS + OUT_FRAC_BITS;
   localparam int QUO_W         = 32;
   localparam int PRE_SHIFT     = QUO_W - SCALE;
   localparam int NUM_ELEM      = 9;
   localparam int DIV_STAGES    = QUO_W;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [32:0] POS_LIMIT = 33'h0_7FFF_FFFF;
   localparam logic [32:0] NEG_LIMIT = 33'h0_8000_0000;
   localparam logic [31:0] POS_SAT   = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_SAT   = 32'h8000_0000;

   typedef logic [15:0] elem_type;
   typedef logic [32:0] adj_type;
   typedef logic [48:0] det_type;

   // adjugate element k = a[i0]*a[j0] - a[i1]*a[j1]
   localparam logic [3:0] ADJ_IDX [NUM_ELEM][4] = '{
      '{4'd4, 4'd8, 4'd7, 4'd5},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd3, 4'd2, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd6, 4'd4},
      '{4'd6, 4'd1, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd3, 4'd1}
   };

   typedef struct packed {
      adj_type [NUM_ELEM-1:0] adj;
      det_type                det;
   } job_type;

   typedef struct packed {
      logic [47:0] rem;
      logic [31:0] quo;
      logic [31:0] dlo;
      logic        neg;
      logic        ovf;
   } lane_type;

   typedef struct packed {
      lane_type [NUM_ELEM-1:0] lane;
      logic [47:0]             dabs;
      det_type                 det;
      logic                    sing;
   } stage_type;

endpackage

// File: src/matrix3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 fixed-point matrix inverse
// Adjugate over determinant, Q8.8 in, Q16.16 saturating out, with the exact
// Q25.24 determinant and a singular flag.
// ----------------------------------------------------------------------------
// Takes one matrix per cycle unless the full queue stalls it and returns one
// item per cycle while rsp_ready is high. It holds three stages of products,
// adjugate and determinant terms, one queue slot, one setup stage, 32 stages
// of the restoring dividers (one quotient bit each, nine lanes in lockstep)
// and the round/saturate output register. A four-entry queue separates the
// front end from the divider so either side can stall independently.
module matrix3_inverse (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m02,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_i00,
   output logic signed [31:0] rsp_i01,
   output logic signed [31:0] rsp_i02,
   output logic signed [31:0] rsp_i10,
   output logic signed [31:0] rsp_i11,
   output logic signed [31:0] rsp_i12,
   output logic signed [31:0] rsp_i20,
   output logic signed [31:0] rsp_i21,
   output logic signed [31:0] rsp_i22,
   output logic signed [48:0] rsp_det_value,
   output logic               rsp_singular
);

   m3inv_pkg::elem_type [m3inv_pkg::NUM_ELEM-1:0] elem;
   m3inv_pkg::job_type   push_job, head_job;
   logic                 push, pop, q_full, q_empty;
   logic [m3inv_pkg::NUM_ELEM-1:0][31:0] inv;
   m3inv_pkg::det_type   det_value;

   assign elem[0] = req_m00;
   assign elem[1] = req_m01;
   assign elem[2] = req_m02;
   assign elem[3] = req_m10;
   assign elem[4] = req_m11;
   assign elem[5] = req_m12;
   assign elem[6] = req_m20;
   assign elem[7] = req_m21;
   assign elem[8] = req_m22;

   m3i_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .elem      (elem),
      .q_full    (q_full),
      .push      (push),
      .job       (push_job)
   );

   m3i_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   m3i_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_empty   (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .inv       (inv),
      .det_value (det_value),
      .singular  (rsp_singular)
   );

   assign rsp_i00       = inv[0];
   assign rsp_i01       = inv[1];
   assign rsp_i02       = inv[2];
   assign rsp_i10       = inv[3];
   assign rsp_i11       = inv[4];
   assign rsp_i12       = inv[5];
   assign rsp_i20       = inv[6];
   assign rsp_i21       = inv[7];
   assign rsp_i22       = inv[8];
   assign rsp_det_value = det_value;

endmodule

// File: src/m3i_front.sv
// ----------------------------------------------------------------------------
// m3i_front: cofactor and determinant front end
// Accepts one matrix per cycle unless the full queue stalls it, forms the 2x2
// products, adjugate and determinant over three register stages; pushes jobs to it.
// ----------------------------------------------------------------------------
module m3i_front (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  m3inv_pkg::elem_type [m3inv_pkg::NUM_ELEM-1:0] elem,
   input  logic                                         q_full,
   output logic                                         push,
   output m3inv_pkg::job_type                           job
);

   logic                      adv;
   logic                      v1_ff, v2_ff, v3_ff;
   logic signed [31:0]        prod_ff [18];
   logic signed [31:0]        prod_in [18];
   logic signed [15:0]        top1_ff [3];
   logic signed [15:0]        top2_ff [3];
   logic signed [32:0]        adj2_ff [9];
   logic signed [32:0]        adj3_ff [9];
   logic signed [48:0]        term_ff [3];
   logic signed [48:0]        term_in [3];
   logic signed [48:0]        det_sum;

   assign adv       = !v3_ff || !q_full;
   assign req_ready = adv;
   assign push      = v3_ff && !q_full;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         prod_in[2*k]   = $signed(elem[m3inv_pkg::ADJ_IDX[k][0]])
                        * $signed(elem[m3inv_pkg::ADJ_IDX[k][1]]);
         prod_in[2*k+1] = $signed(elem[m3inv_pkg::ADJ_IDX[k][2]])
                        * $signed(elem[m3inv_pkg::ADJ_IDX[k][3]]);
      end
      for (int k = 0; k < 3; k++) begin
         term_in[k] = 49'(top2_ff[k]) * 49'(adj2_ff[3*k]);
      end
      det_sum = term_ff[0] + term_ff[1] + term_ff[2];
      for (int k = 0; k < 9; k++) begin
         job.adj[k] = adj3_ff[k];
      end
      job.det = det_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         for (int k = 0; k < 3; k++) begin
            top1_ff[k] <= $signed(elem[k]);
            top2_ff[k] <= top1_ff[k];
         end
         for (int k = 0; k < 9; k++) begin
            adj2_ff[k] <= 33'(prod_ff[2*k]) - 33'(prod_ff[2*k+1]);
         end
         adj3_ff <= adj2_ff;
         term_ff <= term_in;
      end
   end

endmodule

// File: src/m3i_queue.sv
// ----------------------------------------------------------------------------
// m3i_queue: job queue between front end and divider
// Small register queue that decouples the two sides.
// ----------------------------------------------------------------------------
module m3i_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  m3inv_pkg::job_type push_job,
   input  logic               pop,
   output m3inv_pkg::job_type head_job,
   output logic               full,
   output logic               empty
);

   m3inv_pkg::job_type entry_ff [m3inv_pkg::QUEUE_DEPTH];
   logic [1:0]         wr_ff, rd_ff;
   logic [2:0]         count_ff;

   assign full     = (count_ff == 3'(m3inv_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == 3'd0);
   assign head_job = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 2'd0;
         rd_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 2'd1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 2'd1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 3'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

// File: src/m3i_back.sv
// ----------------------------------------------------------------------------
// m3i_back: scaled division pipeline and result register
// Nine restoring dividers in lockstep, one quotient bit per stage, then
// rounding, saturation and the singular case into the output register.
// ----------------------------------------------------------------------------
module m3i_back (
   input  logic                                clock,
   input  logic                                reset,
   input  m3inv_pkg::job_type                  head_job,
   input  logic                                q_empty,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [m3inv_pkg::NUM_ELEM-1:0][31:0] inv,
   output m3inv_pkg::det_type                  det_value,
   output logic                                singular
);

   logic                                 adv;
   logic [m3inv_pkg::DIV_STAGES:0]       v_ff;
   m3inv_pkg::stage_type                 st_ff [m3inv_pkg::DIV_STAGES+1];
   m3inv_pkg::stage_type                 st_in [m3inv_pkg::DIV_STAGES+1];
   logic [8:0][31:0]                     inv_ff, inv_in;
   m3inv_pkg::det_type                   det_ff;
   logic                                 sing_ff;
   logic                                 out_v_ff;

   function automatic m3inv_pkg::stage_type prep(m3inv_pkg::job_type j);
      m3inv_pkg::stage_type o;
      logic [48:0]          dneg;
      logic [32:0]          amag;
      logic [31:0]          un;
      dneg   = j.det[48] ? (~j.det + 49'd1) : j.det;
      o.dabs = dneg[47:0];
      o.det  = j.det;
      o.sing = (j.det == '0);
      for (int l = 0; l < 9; l++) begin
         amag = j.adj[l][32] ? (~j.adj[l] + 33'd1) : j.adj[l];
         un   = amag[31:0];
         o.lane[l].neg = j.adj[l][32] ^ j.det[48];
         o.lane[l].ovf = 56'(un) >= (56'(dneg[47:0]) << m3inv_pkg::PRE_SHIFT);
         o.lane[l].rem = 48'(un >> m3inv_pkg::PRE_SHIFT);
         o.lane[l].dlo = un << m3inv_pkg::SCALE;
         o.lane[l].quo = '0;
      end
      return o;
   endfunction

   function automatic m3inv_pkg::stage_type step(m3inv_pkg::stage_type s);
      m3inv_pkg::stage_type o;
      logic [48:0]          rs;
      logic [48:0]          d;
      o = s;
      d = {1'b0, s.dabs};
      for (int l = 0; l < 9; l++) begin
         rs = {s.lane[l].rem, s.lane[l].dlo[31]};
         if (rs >= d) begin
            o.lane[l].rem = 48'(rs - d);
            o.lane[l].quo = {s.lane[l].quo[30:0], 1'b1};
         end else begin
            o.lane[l].rem = rs[47:0];
            o.lane[l].quo = {s.lane[l].quo[30:0], 1'b0};
         end
         o.lane[l].dlo = {s.lane[l].dlo[30:0], 1'b0};
      end
      return o;
   endfunction

   assign adv = !out_v_ff || rsp_ready;
   assign pop = adv && !q_empty;

   always_comb begin
      logic        rnd;
      logic [32:0] qr;
      m3inv_pkg::stage_type f;
      st_in[0] = prep(head_job);
      for (int k = 1; k <= m3inv_pkg::DIV_STAGES; k++) begin
         st_in[k] = step(st_ff[k-1]);
      end
      f = st_ff[m3inv_pkg::DIV_STAGES];
      for (int l = 0; l < 9; l++) begin
         rnd = {f.lane[l].rem, 1'b0} >= {1'b0, f.dabs};
         qr  = {1'b0, f.lane[l].quo} + 33'(rnd);
         if (f.sing) begin
            inv_in[l] = '0;
         end else if (f.lane[l].neg) begin
            if (f.lane[l].ovf || qr > m3inv_pkg::NEG_LIMIT) begin
               inv_in[l] = m3inv_pkg::NEG_SAT;
            end else begin
               inv_in[l] = 32'(~qr + 33'd1);
            end
         end else begin
            if (f.lane[l].ovf || qr > m3inv_pkg::POS_LIMIT) begin
               inv_in[l] = m3inv_pkg::POS_SAT;
            end else begin
               inv_in[l] = qr[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff     <= {v_ff[m3inv_pkg::DIV_STAGES-1:0], pop};
         out_v_ff <= v_ff[m3inv_pkg::DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff   <= st_in;
         inv_ff  <= inv_in;
         det_ff  <= st_ff[m3inv_pkg::DIV_STAGES].det;
         sing_ff <= st_ff[m3inv_pkg::DIV_STAGES].sing;
      end
   end

   assign rsp_valid = out_v_ff;
   assign inv       = inv_ff;
   assign det_value = det_ff;
   assign singular  = sing_ff;

endmodule

// File: dv/matrix3_inverse_test.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_test: self-checking bench for the 3x3 matrix inverse
// Streams matrices through the block under varying idle and stall patterns,
// predicts the adjugate, determinant and rounded, saturated Q16.16 inverse
// for each accepted item and compares every returned item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix3_inverse_test;

   typedef struct {
      logic signed [15:0] m [9];
   } matrix_type;

   typedef struct {
      logic signed [31:0] inv [9];
      logic signed [48:0] det;
      logic               sing;
   } inverse_type;

   localparam int MAX_CYCLES = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_m [9];
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_i [9];
   logic signed [48:0] rsp_det_value;
   logic rsp_singular;

   matrix_type  pending_items [$];
   inverse_type expected_inverses [$];
   matrix_type  cur_item;
   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_recv = 1'b0;

   initial for (int k = 0; k < 9; k++) req_m[k] = '0;

   always #5 clock = ~clock;

   matrix3_inverse dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_i00(rsp_i[0]), .rsp_i01(rsp_i[1]), .rsp_i02(rsp_i[2]),
      .rsp_i10(rsp_i[3]), .rsp_i11(rsp_i[4]), .rsp_i12(rsp_i[5]),
      .rsp_i20(rsp_i[6]), .rsp_i21(rsp_i[7]), .rsp_i22(rsp_i[8]),
      .rsp_det_value(rsp_det_value), .rsp_singular(rsp_singular)
   );

   function automatic logic [31:0] scaled_quotient(longint num, longint den);
      logic        neg;
      logic [63:0] un, ud, q, r;
      logic        big;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = un / ud;
      r = un % ud;
      big = q > 64'h8000_0000;
      for (int k = 0; k < m3inv_pkg::IN_FRAC_BITS + m3inv_pkg::OUT_FRAC_BITS && !big;
           k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= ud) begin
            r = r - ud;
            q[0] = 1'b1;
         end
         if (q > 64'h8000_0000) big = 1'b1;
      end
      if (!big && r >= ud - r) q = q + 1;
      if (neg) begin
         if (big || q > 64'h8000_0000) return m3inv_pkg::NEG_SAT;
         return 32'(-q);
      end
      if (big || q > 64'h7FFF_FFFF) return m3inv_pkg::POS_SAT;
      return q[31:0];
   endfunction

   function automatic inverse_type invert_matrix(matrix_type x);
      inverse_type res;
      longint a [9];
      longint adj [9];
      longint det;
      for (int k = 0; k < 9; k++) a[k] = x.m[k];
      adj[0] = a[4] * a[8] - a[7] * a[5];
      adj[1] = a[2] * a[7] - a[1] * a[8];
      adj[2] = a[1] * a[5] - a[2] * a[4];
      adj[3] = a[5] * a[6] - a[3] * a[8];
      adj[4] = a[0] * a[8] - a[2] * a[6];
      adj[5] = a[3] * a[2] - a[0] * a[5];
      adj[6] = a[3] * a[7] - a[6] * a[4];
      adj[7] = a[6] * a[1] - a[0] * a[7];
      adj[8] = a[0] * a[4] - a[3] * a[1];
      det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
      res.det = 49'(det);
      res.sing = (det == 0);
      for (int k = 0; k < 9; k++)
         res.inv[k] = res.sing ? 32'sd0 : scaled_quotient(adj[k], det);
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_inverses.push_back(invert_matrix(cur_item));
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_item = pending_items.pop_front();
            req_valid <= 1'b1;
            for (int k = 0; k < 9; k++) req_m[k] <= cur_item.m[k];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      inverse_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_inverses.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               want = expected_inverses.pop_front();
               for (int k = 0; k < 9; k++)
                  if (rsp_i[k] !== want.inv[k])
                     report_mismatch($sformatf("i%0d%0d", k / 3, k % 3),
                                     rsp_i[k], want.inv[k]);
               if (rsp_det_value !== want.det)
                  report_mismatch("det_value", rsp_det_value, want.det);
               if (rsp_singular !== want.sing)
                  report_mismatch("singular", rsp_singular, want.sing);
            end
         end
         rsp_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= MAX_CYCLES) begin
         $display("timeout");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic matrix_type random_matrix();
      matrix_type x;
      int mode;
      mode = $urandom_range(9);
      for (int k = 0; k < 9; k++) begin
         case (mode)
            0: x.m[k] = 16'($urandom);
            1, 2: x.m[k] = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            3: x.m[k] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            4: x.m[k] = $signed(16'($urandom_range(0, 7))) - 16'sd3;
            default: x.m[k] = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
         endcase
      end
      // force a dependent row now and then to get singular matrices; mode 6 gives a diagonal matrix
      if (mode == 5 && $urandom_range(1))
         for (int k = 0; k < 3; k++) x.m[6 + k] = x.m[k];
      else if (mode == 6)
         for (int k = 0; k < 9; k++)
            x.m[k] = (k % 4 == 0) ? 16'($urandom_range(1, 2047)) : 16'sd0;
      return x;
   endfunction

   task automatic add_diag(logic signed [15:0] d0, logic signed [15:0] d1,
                           logic signed [15:0] d2);
      matrix_type x;
      for (int k = 0; k < 9; k++) x.m[k] = '0;
      x.m[0] = d0; x.m[4] = d1; x.m[8] = d2;
      pending_items.push_back(x);
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_inverses.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      matrix_type x;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed
      add_diag(16'sh0100, 16'sh0100, 16'sh0100);
      add_diag(16'sh0200, 16'sh0400, 16'sh0080);
      add_diag(16'sh0001, 16'sh0001, 16'sh0001);
      add_diag(-16'sh0001, 16'sh0001, 16'sh0001);
      add_diag(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      add_diag(16'sh8000, 16'sh8000, 16'sh8000);
      add_diag(16'sh0300, 16'sh0300, 16'sh0300);
      add_diag(16'sh0300, -16'sh0300, 16'sh0700);
      add_diag(16'sh0000, 16'sh0100, 16'sh0100);
      add_diag(16'sh0001, 16'sh0100, 16'sh0100);
      add_diag(-16'sh0001, 16'sh0100, 16'sh0100);
      add_diag(16'sh8000, 16'sh0001, 16'sh0001);
      for (int k = 0; k < 9; k++) x.m[k] = '0;
      pending_items.push_back(x);
      for (int k = 0; k < 9; k++) x.m[k] = 16'shFFFF;
      pending_items.push_back(x);
      for (int k = 0; k < 9; k++) x.m[k] = (k % 2) ? 16'sh7FFF : 16'sh8000;
      pending_items.push_back(x);
      for (int k = 0; k < 9; k++) x.m[k] = 16'(k + 1) << 8;
      pending_items.push_back(x);
      x.m[8] = 16'sh0A00;
      pending_items.push_back(x);
      for (int k = 0; k < 9; k++) x.m[k] = 16'sh5555 ^ 16'(k * 16'h1111);
      pending_items.push_back(x);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? 60 : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? 60 : 0;
         if (phase == 3) begin
            send_idle_pct = 6;
            recv_stall_pct = 6;
         end
         for (int n = 0; n < 400; n++) pending_items.push_back(random_matrix());
         if (phase == 0) begin
            hold_recv = 1'b1;
            repeat (200) @(posedge clock);
            hold_recv = 1'b0;
         end
         wait_drained();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
